FILE: src/sat_pkg.sv
// shared constants, gear tables and phase codes for the scope auto-set timebase
// no dependencies

package sat_pkg;

  localparam int SAMPLES_PER_BLOCK = 256;

  localparam int FREQ_W   = 24;
  localparam int SPB_W    = $clog2(SAMPLES_PER_BLOCK + 1);
  localparam int PROD_W   = FREQ_W + SPB_W;
  localparam int DIST_W   = PROD_W + 1;

  // target divisor 80 = 5 << 4, the odd part through a reciprocal multiplication
  localparam int TGT_DIV_SH  = 4;
  localparam int TGT_DIV_ODD = 5;
  localparam int RECIP_SH    = 31;
  localparam int RECIP_W     = 29;
  localparam logic [RECIP_W-1:0] RECIP_ODD =
    RECIP_W'(((64'd1 << RECIP_SH) + 64'(TGT_DIV_ODD) - 64'd1) / 64'(TGT_DIV_ODD));

  localparam int GEAR_CNT = 11;
  localparam int GEAR_W   = 4;
  localparam int RATE_W   = 17;
  localparam int REG_W    = 16;
  localparam int CFG_IDX_W = 2;

  localparam logic [RATE_W-1:0] FAIL_RATE  = RATE_W'(50);
  localparam logic [RATE_W-1:0] RESET_RATE = RATE_W'(50000);
  localparam logic [FREQ_W-1:0] FREQ_MIN_Q4 = FREQ_W'(16);

  localparam logic [RATE_W-1:0] RATE_TABLE [GEAR_CNT] = '{
    RATE_W'(100000), RATE_W'(50000), RATE_W'(20000), RATE_W'(10000),
    RATE_W'(5000), RATE_W'(2000), RATE_W'(1000), RATE_W'(500),
    RATE_W'(200), RATE_W'(100), RATE_W'(50)
  };

  localparam int WAIT_NUM = SAMPLES_PER_BLOCK * 1200;

  localparam logic [RATE_W-1:0] WAIT_TABLE [GEAR_CNT] = '{
    RATE_W'(WAIT_NUM / 100000), RATE_W'(WAIT_NUM / 50000), RATE_W'(WAIT_NUM / 20000),
    RATE_W'(WAIT_NUM / 10000), RATE_W'(WAIT_NUM / 5000), RATE_W'(WAIT_NUM / 2000),
    RATE_W'(WAIT_NUM / 1000), RATE_W'(WAIT_NUM / 500), RATE_W'(WAIT_NUM / 200),
    RATE_W'(WAIT_NUM / 100), RATE_W'(WAIT_NUM / 50)
  };

  typedef enum logic [2:0] {
    PH_IDLE     = 3'd0,
    PH_PREPARE  = 3'd1,
    PH_SET_GEAR = 3'd2,
    PH_WAIT     = 3'd3,
    PH_ANALYZE  = 3'd4,
    PH_LOCKED   = 3'd5,
    PH_FAIL     = 3'd6
  } phase_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_NOISE_THR = 2'd0,
    REG_MIN_WAIT  = 2'd1,
    REG_MAX_WAIT  = 2'd2
  } cfg_reg_t;

endpackage

FILE: src/sat_div_const.sv
// division by the constant 80: a shift by four and a reciprocal multiplication by 1/5,
// quotient registered in the cycle after start; depends on sat_pkg

module sat_div_const import sat_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [PROD_W-1:0] num,
  output logic              done,
  output logic [PROD_W-1:0] quot
);

  localparam int X_W   = PROD_W - TGT_DIV_SH;
  localparam int MUL_W = X_W + RECIP_W;

  logic [X_W-1:0]   x;
  logic [MUL_W-1:0] full;

  assign x    = num[PROD_W-1:TGT_DIV_SH];
  assign full = MUL_W'(x) * MUL_W'(RECIP_ODD);

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= start;
      if (start) begin
        quot <= PROD_W'(full[MUL_W-1:RECIP_SH]);
      end
    end
  end

endmodule

FILE: src/sat_gear_search.sv
// nearest-gear search: one gear per cycle through a shared distance and compare unit
// depends on sat_pkg

module sat_gear_search import sat_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [PROD_W-1:0] target,
  output logic              done,
  output logic [GEAR_W-1:0] best
);

  logic [PROD_W-1:0] tgt;
  logic [GEAR_W-1:0] k;
  logic              busy;
  logic [DIST_W-1:0] best_d;
  logic [PROD_W-1:0] r;
  logic [DIST_W-1:0] d;

  always_comb begin
    r = PROD_W'(RATE_TABLE[k]);
    if (r >= tgt) begin
      d = DIST_W'(r - tgt);
    end else begin
      d = {tgt - r, 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      k    <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        k    <= '0;
        tgt  <= target;
      end else if (busy) begin
        if (k == '0 || d < best_d) begin
          best_d <= d;
          best   <= k;
        end
        if (k == GEAR_W'(GEAR_CNT - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          k <= k + GEAR_W'(1);
        end
      end
    end
  end

endmodule

FILE: src/scope_autoset_timebase.sv
// scope auto-set timebase sequencer: top level with phase logic and result register
// a pass that does not lock a gear gives its result in the cycle after its beat
// a locking pass scales the target through the constant divider and then searches the
// eleven gears one per cycle; one pass at a time
// synchronous active-high reset: idle phase, gear 0, 50 kHz, default registers
// depends on sat_pkg, sat_div_const, sat_gear_search

module scope_autoset_timebase import sat_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [79:0]          s_tdata,   // running, now_ms, vpp_mv, measured_freq_q4
  input  logic                 s_tuser,   // action
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [31:0]          m_tdata,   // sample_rate, rate_written, auto_phase, gear_index
  input  logic                 cfg_wen,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [REG_W-1:0]     cfg_wdata
);

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_DIV    = 3'b010,
    ST_SEARCH = 3'b100
  } seq_state_t;

  seq_state_t state;

  logic [REG_W-1:0]  noise_thr;
  logic [REG_W-1:0]  min_wait;
  logic [REG_W-1:0]  max_wait;

  phase_t            phase;
  logic [GEAR_W-1:0] scan_gear;
  logic [RATE_W-1:0] rate_now;
  logic [31:0]       wait_begin;
  logic [REG_W-1:0]  wait_length;

  logic [RATE_W-1:0] out_rate;
  logic              out_written;
  phase_t            out_phase;
  logic [GEAR_W-1:0] out_gear;

  logic              running_in;
  logic [31:0]       now_in;
  logic [15:0]       vpp_in;
  logic [FREQ_W-1:0] freq_in;
  logic              accept;

  phase_t            ph_eff;
  phase_t            phase_next;
  logic [GEAR_W-1:0] scan_gear_next;
  logic [RATE_W-1:0] rate_now_next;
  logic [31:0]       wait_begin_next;
  logic [REG_W-1:0]  wait_length_next;
  logic              written_next;
  logic              go_lock;
  logic [GEAR_W-1:0] gidx;
  logic [GEAR_W-1:0] gear_inc;
  logic [RATE_W-1:0] w_raw;
  logic [RATE_W-1:0] w_lo;
  logic [31:0]       elapsed;

  logic              div_done;
  logic [PROD_W-1:0] div_quot;
  logic [PROD_W-1:0] prod;
  logic              srch_done;
  logic [GEAR_W-1:0] srch_best;

  assign running_in = s_tdata[0];
  assign now_in     = s_tdata[32:1];
  assign vpp_in     = s_tdata[48:33];
  assign freq_in    = s_tdata[72:49];

  assign s_tready = (state == ST_IDLE) && (!m_tvalid || m_tready);
  assign accept   = s_tvalid && s_tready;

  assign m_tdata = {7'b0, out_gear, out_phase, out_written, out_rate};

  assign prod = PROD_W'(freq_in) * PROD_W'(SAMPLES_PER_BLOCK);

  always_comb begin
    ph_eff           = (s_tuser && running_in) ? PH_PREPARE : phase;
    phase_next       = phase;
    scan_gear_next   = scan_gear;
    rate_now_next    = rate_now;
    wait_begin_next  = wait_begin;
    wait_length_next = wait_length;
    written_next     = 1'b0;
    go_lock          = 1'b0;
    gidx     = (scan_gear > GEAR_W'(GEAR_CNT - 1)) ? GEAR_W'(GEAR_CNT - 1) : scan_gear;
    gear_inc = scan_gear + GEAR_W'(1);
    w_raw    = WAIT_TABLE[gidx];
    w_lo     = (w_raw < RATE_W'(min_wait)) ? RATE_W'(min_wait) : w_raw;
    elapsed  = now_in - wait_begin;
    case (ph_eff)
      PH_PREPARE: begin
        scan_gear_next = '0;
        phase_next     = PH_SET_GEAR;
      end
      PH_SET_GEAR: begin
        rate_now_next    = RATE_TABLE[gidx];
        written_next     = 1'b1;
        wait_length_next = (w_lo > RATE_W'(max_wait)) ? max_wait : w_lo[REG_W-1:0];
        wait_begin_next  = now_in;
        phase_next       = PH_WAIT;
      end
      PH_WAIT: begin
        if (elapsed >= 32'(wait_length)) begin
          phase_next = PH_ANALYZE;
        end
      end
      PH_ANALYZE: begin
        if (vpp_in >= noise_thr && freq_in > FREQ_MIN_Q4) begin
          go_lock = 1'b1;
        end else begin
          scan_gear_next = gear_inc;
          if (gear_inc >= GEAR_W'(GEAR_CNT)) begin
            rate_now_next = FAIL_RATE;
            written_next  = 1'b1;
            phase_next    = PH_FAIL;
          end else begin
            phase_next = PH_SET_GEAR;
          end
        end
      end
      default: begin
      end
    endcase
  end

  sat_div_const u_div (
    .clk   (clk),
    .rst   (rst),
    .start (accept && go_lock),
    .num   (prod),
    .done  (div_done),
    .quot  (div_quot)
  );

  sat_gear_search u_search (
    .clk    (clk),
    .rst    (rst),
    .start  (div_done),
    .target (div_quot),
    .done   (srch_done),
    .best   (srch_best)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      m_tvalid    <= 1'b0;
      noise_thr   <= REG_W'(150);
      min_wait    <= REG_W'(150);
      max_wait    <= REG_W'(6000);
      phase       <= PH_IDLE;
      scan_gear   <= '0;
      rate_now    <= RESET_RATE;
      wait_begin  <= '0;
      wait_length <= '0;
    end else begin
      if (cfg_wen) begin
        case (cfg_index)
          REG_NOISE_THR: noise_thr <= cfg_wdata;
          REG_MIN_WAIT:  min_wait  <= cfg_wdata;
          REG_MAX_WAIT:  max_wait  <= cfg_wdata;
          default: begin
          end
        endcase
      end
      if (m_tvalid && m_tready && !(accept && !go_lock)) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            if (go_lock) begin
              state <= ST_DIV;
            end else begin
              phase       <= phase_next;
              scan_gear   <= scan_gear_next;
              rate_now    <= rate_now_next;
              wait_begin  <= wait_begin_next;
              wait_length <= wait_length_next;
              out_rate    <= rate_now_next;
              out_written <= written_next;
              out_phase   <= phase_next;
              out_gear    <= scan_gear_next;
              m_tvalid    <= 1'b1;
            end
          end
        end
        ST_DIV: begin
          if (div_done) begin
            state <= ST_SEARCH;
          end
        end
        ST_SEARCH: begin
          if (srch_done) begin
            rate_now    <= RATE_TABLE[srch_best];
            phase       <= PH_LOCKED;
            out_rate    <= RATE_TABLE[srch_best];
            out_written <= 1'b1;
            out_phase   <= PH_LOCKED;
            out_gear    <= scan_gear;
            m_tvalid    <= 1'b1;
            state       <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: sim/scope_autoset_timebase_tb.sv
// self-checking testbench for the scope auto-set timebase sequencer: directed table, then
// random auto-set sessions under several register settings, checked against a local predictor
// depends on sat_pkg and scope_autoset_timebase

module scope_autoset_timebase_tb;
  import sat_pkg::*;

  localparam int LIMIT_CYCLES = 1000000;
  localparam int DRAIN_CYCLES = 100;
  localparam int HOLD_CYCLES = 400;
  localparam int PHASE_ITEMS = 255;
  localparam int SETTING_PHASES = 6;
  localparam int DIR_ROWS = 22;
  localparam logic [CFG_IDX_W-1:0] REG_RESERVED = 2'd3;

  typedef struct packed {
    logic        action;
    logic        running;
    logic [31:0] now_ms;
    logic [15:0] vpp_mv;
    logic [23:0] freq_q4;
  } pass_in_t;

  typedef struct packed {
    logic [GEAR_W-1:0] gear_index;
    phase_t            auto_phase;
    logic              rate_written;
    logic [RATE_W-1:0] sample_rate;
  } timebase_t;

  typedef struct packed {
    pass_in_t  pass;
    logic      typed;
    timebase_t want;
  } dir_row_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [79:0]          s_tdata = '0;   // running, now_ms, vpp_mv, measured_freq_q4
  logic                 s_tuser = 1'b0; // action
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [31:0]          m_tdata;        // sample_rate, rate_written, auto_phase, gear_index
  logic                 cfg_wen = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [REG_W-1:0]     cfg_wdata = '0;

  scope_autoset_timebase u_top (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_wen(cfg_wen), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always #4 clk = ~clk;

  // predictor state and register copy
  phase_t            st_phase = PH_IDLE;
  logic [GEAR_W-1:0] st_gear = '0;
  logic [RATE_W-1:0] st_rate = RESET_RATE;
  logic [31:0]       st_begin = '0;
  logic [15:0]       st_len = '0;
  logic [15:0]       cfg_thr = 16'd150;
  logic [15:0]       cfg_min = 16'd150;
  logic [15:0]       cfg_max = 16'd6000;

  timebase_t timebase_queue [$];
  int fail_count = 0;
  int results_seen = 0;
  int cycle_count = 0;
  int locks_made = 0;
  int scans_failed = 0;
  int restarts = 0;
  int send_gap_pct = 35;
  int recv_gap_pct = 81;
  int hold_gen = 0;

  // stimulus session state
  logic [31:0] clk_ms = '0;
  int sess_left = 0;
  int sess_kind = 0;

  dir_row_t directed_rows [DIR_ROWS];

  function automatic dir_row_t dir_row(input logic a, input logic run, input logic [31:0] now,
                                       input logic [15:0] vpp, input logic [23:0] freq,
                                       input logic typed, input logic [RATE_W-1:0] rate,
                                       input logic wr, input phase_t ph,
                                       input logic [GEAR_W-1:0] gear);
    dir_row_t r;
    r.pass = '{action: a, running: run, now_ms: now, vpp_mv: vpp, freq_q4: freq};
    r.typed = typed;
    r.want = '{gear_index: gear, auto_phase: ph, rate_written: wr, sample_rate: rate};
    return r;
  endfunction

  function automatic int closest_gear(input logic [23:0] freq);
    logic [63:0] target;
    logic [63:0] span;
    logic [63:0] best_span;
    logic [63:0] r;
    int best;
    int k;
    target = (64'(freq) * 64'(SAMPLES_PER_BLOCK)) / 64'd80;
    best_span = '1;
    best = 0;
    for (k = 0; k < GEAR_CNT; k++) begin
      r = 64'(RATE_TABLE[k]);
      span = (r > target) ? r - target : target - r;
      if (r < target) span = span * 2;
      if (span < best_span) begin
        best_span = span;
        best = k;
      end
    end
    return best;
  endfunction

  task automatic step_timebase(input pass_in_t p, output timebase_t r);
    logic [RATE_W-1:0] rate;
    logic [31:0] settle;
    logic [31:0] elapsed;
    logic written;
    written = 1'b0;
    if (p.action && p.running) begin
      st_phase = PH_PREPARE;
      restarts++;
    end
    case (st_phase)
      PH_PREPARE: begin
        st_gear = '0;
        st_phase = PH_SET_GEAR;
      end
      PH_SET_GEAR: begin
        rate = RATE_TABLE[(st_gear < GEAR_CNT) ? int'(st_gear) : GEAR_CNT - 1];
        settle = (SAMPLES_PER_BLOCK * 1200) / 32'(rate);
        st_rate = rate;
        written = 1'b1;
        if (settle < 32'(cfg_min)) settle = 32'(cfg_min);
        if (settle > 32'(cfg_max)) settle = 32'(cfg_max);
        st_len = settle[15:0];
        st_begin = p.now_ms;
        st_phase = PH_WAIT;
      end
      PH_WAIT: begin
        elapsed = p.now_ms - st_begin;
        if (elapsed >= 32'(st_len)) st_phase = PH_ANALYZE;
      end
      PH_ANALYZE: begin
        if (p.vpp_mv >= cfg_thr && p.freq_q4 > FREQ_MIN_Q4) begin
          st_rate = RATE_TABLE[closest_gear(p.freq_q4)];
          written = 1'b1;
          st_phase = PH_LOCKED;
          locks_made++;
        end else begin
          st_gear = st_gear + 4'd1;
          if (st_gear >= GEAR_CNT) begin
            st_rate = FAIL_RATE;
            written = 1'b1;
            st_phase = PH_FAIL;
            scans_failed++;
          end else begin
            st_phase = PH_SET_GEAR;
          end
        end
      end
      default: ;
    endcase
    r = '{gear_index: st_gear, auto_phase: st_phase, rate_written: written, sample_rate: st_rate};
  endtask

  // drives one pass after a random gap and returns at the falling edge after its beat
  task automatic issue_pass(input pass_in_t p, input logic typed, input timebase_t want);
    timebase_t pred;
    step_timebase(p, pred);
    timebase_queue.push_back(typed ? want : pred);
    while ($urandom_range(0, 99) < send_gap_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {7'd0, p.freq_q4, p.vpp_mv, p.now_ms, p.running};
    s_tuser <= p.action;
    @(posedge clk);
    while (s_tready !== 1'b1) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic logic [23:0] pick_freq();
    int top;
    case ($urandom_range(0, 3))
      0: return 24'($urandom_range(17, 24'hFFFFFF));
      1: return 24'($urandom_range(17, 200));
      default: begin
        top = int'(RATE_TABLE[$urandom_range(0, GEAR_CNT - 1)]) * 5 / 8;
        return 24'($urandom_range(17, (top < 17) ? 17 : top));
      end
    endcase
  endfunction

  // mostly well-formed auto-set sessions, with some noise passes
  task automatic make_pass(output pass_in_t p);
    logic [31:0] goal;
    logic faint;
    p.action = 1'b0;
    p.running = ($urandom_range(0, 9) != 0);
    p.vpp_mv = 16'($urandom);
    p.freq_q4 = 24'($urandom);
    if ($urandom_range(0, 99) < 8) begin
      p.action = 1'($urandom);
      p.running = 1'($urandom);
      clk_ms = $urandom;
      p.now_ms = clk_ms;
    end else begin
      if (sess_left == 0 ||
          ((st_phase == PH_IDLE || st_phase == PH_LOCKED || st_phase == PH_FAIL) &&
           $urandom_range(0, 3) == 0)) begin
        p.action = 1'b1;
        p.running = ($urandom_range(0, 7) != 0);
        sess_kind = $urandom_range(0, 2);
        sess_left = (sess_kind == 0) ? 80 : $urandom_range(8, 60);
      end else if ($urandom_range(0, 99) < 2) begin
        p.action = 1'b1;
        p.running = 1'b1;
      end
      if (sess_left > 0) sess_left--;
      if (st_phase == PH_WAIT) begin
        goal = st_begin + 32'(st_len);
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4: clk_ms = goal;
          5, 6: clk_ms = goal - 32'd1;
          default: clk_ms = clk_ms + $urandom_range(0, 2 * int'(st_len) + 1);
        endcase
      end else begin
        clk_ms = clk_ms + $urandom_range(0, 200);
      end
      p.now_ms = clk_ms;
      if (st_phase == PH_ANALYZE && !(p.action && p.running)) begin
        faint = (sess_kind == 0) ? 1'b1 : (sess_kind == 1) ? 1'b0 : 1'($urandom);
        if (faint) begin
          if (cfg_thr != 0 && $urandom_range(0, 1) == 1)
            p.vpp_mv = 16'($urandom_range(0, int'(cfg_thr) - 1));
          else
            p.freq_q4 = 24'($urandom_range(0, 16));
        end else begin
          p.vpp_mv = 16'($urandom_range(int'(cfg_thr), 16'hFFFF));
          p.freq_q4 = pick_freq();
        end
      end
    end
  endtask

  task automatic program_reg(input logic [CFG_IDX_W-1:0] idx, input logic [REG_W-1:0] data);
    cfg_wen <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    case (idx)
      REG_NOISE_THR: cfg_thr = data;
      REG_MIN_WAIT: cfg_min = data;
      REG_MAX_WAIT: cfg_max = data;
      default: ;
    endcase
    @(negedge clk);
  endtask

  // registers change only once every pass in flight has produced its beat
  task automatic apply_settings(input logic [15:0] thr, input logic [15:0] min_w,
                                input logic [15:0] max_w, input logic poke_reserved);
    s_tvalid <= 1'b0;
    while (timebase_queue.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
    program_reg(REG_NOISE_THR, thr);
    program_reg(REG_MIN_WAIT, min_w);
    program_reg(REG_MAX_WAIT, max_w);
    if (poke_reserved) program_reg(REG_RESERVED, 16'($urandom));
    cfg_wen <= 1'b0;
  endtask

  task automatic check_timebase(input timebase_t got);
    timebase_t want;
    if (timebase_queue.size() == 0) begin
      fail_count++;
      if (fail_count <= 10)
        $display("unexpected result beat: rate %0d written %0d phase %0d gear %0d",
                 got.sample_rate, got.rate_written, got.auto_phase, got.gear_index);
    end else begin
      want = timebase_queue.pop_front();
      if (got.sample_rate !== want.sample_rate || got.rate_written !== want.rate_written ||
          got.auto_phase !== want.auto_phase || got.gear_index !== want.gear_index) begin
        fail_count++;
        if (fail_count <= 10)
          $display("result %0d mismatch: expected rate %0d written %0d phase %0d gear %0d, %s",
                   results_seen, want.sample_rate, want.rate_written, want.auto_phase,
                   want.gear_index,
                   $sformatf("got rate %0d written %0d phase %0d gear %0d", got.sample_rate,
                             got.rate_written, got.auto_phase, got.gear_index));
      end
      results_seen++;
    end
  endtask

  always @(posedge clk) begin
    cycle_count++;
    if (!rst && m_tvalid === 1'b1 && m_tready === 1'b1) check_timebase(m_tdata[24:0]);
  end

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    int hold_seen;
    int hold_left;
    hold_seen = 0;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_gen != hold_seen) begin
        hold_seen = hold_gen;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(0, 99) >= recv_gap_pct);
      end
    end
  end

  initial begin
    wait (cycle_count >= LIMIT_CYCLES);
    $display("scope_autoset_timebase verification failed");
    $finish;
  end

  initial begin
    pass_in_t p;
    int ph;
    int i;
    directed_rows = '{
      dir_row(1'b0, 1'b0, 32'd0, 16'd0, 24'd0, 1'b1, 17'd50000, 1'b0, PH_IDLE, 4'd0),
      // start while stopped is ignored
      dir_row(1'b1, 1'b0, 32'd10, 16'hFFFF, 24'hFFFFFF, 1'b1, 17'd50000, 1'b0, PH_IDLE, 4'd0),
      dir_row(1'b1, 1'b1, 32'd20, 16'd0, 24'd0, 1'b1, 17'd50000, 1'b0, PH_SET_GEAR, 4'd0),
      dir_row(1'b0, 1'b1, 32'd100, 16'd0, 24'd0, 1'b1, 17'd100000, 1'b1, PH_WAIT, 4'd0),
      dir_row(1'b0, 1'b1, 32'd249, 16'd0, 24'd0, 1'b1, 17'd100000, 1'b0, PH_WAIT, 4'd0),
      dir_row(1'b0, 1'b1, 32'd250, 16'd0, 24'd0, 1'b1, 17'd100000, 1'b0, PH_ANALYZE, 4'd0),
      dir_row(1'b0, 1'b1, 32'd260, 16'd149, 24'hFFFFFF, 1'b1, 17'd100000, 1'b0, PH_SET_GEAR,
              4'd1),
      dir_row(1'b0, 1'b1, 32'd300, 16'd0, 24'd0, 1'b1, 17'd50000, 1'b1, PH_WAIT, 4'd1),
      dir_row(1'b0, 1'b1, 32'd450, 16'd0, 24'd0, 1'b1, 17'd50000, 1'b0, PH_ANALYZE, 4'd1),
      dir_row(1'b0, 1'b1, 32'd460, 16'd150, 24'd16, 1'b1, 17'd50000, 1'b0, PH_SET_GEAR, 4'd2),
      // settle wait across the millisecond wrap
      dir_row(1'b0, 1'b1, 32'hFFFFFFF0, 16'd0, 24'd0, 1'b1, 17'd20000, 1'b1, PH_WAIT, 4'd2),
      dir_row(1'b0, 1'b1, 32'h00000086, 16'd0, 24'd0, 1'b1, 17'd20000, 1'b0, PH_ANALYZE, 4'd2),
      dir_row(1'b0, 1'b1, 32'd90, 16'hFFFF, 24'hFFFFFF, 1'b1, 17'd100000, 1'b1, PH_LOCKED,
              4'd2),
      dir_row(1'b0, 1'b0, 32'd95, 16'd0, 24'd0, 1'b1, 17'd100000, 1'b0, PH_LOCKED, 4'd2),
      dir_row(1'b1, 1'b1, 32'd1000, 16'd0, 24'd0, 1'b1, 17'd100000, 1'b0, PH_SET_GEAR, 4'd0),
      dir_row(1'b0, 1'b1, 32'd1000, 16'd0, 24'd0, 1'b1, 17'd100000, 1'b1, PH_WAIT, 4'd0),
      // restart in the middle of a scan
      dir_row(1'b1, 1'b1, 32'd1100, 16'd0, 24'd0, 1'b1, 17'd100000, 1'b0, PH_SET_GEAR, 4'd0),
      dir_row(1'b0, 1'b1, 32'd2000, 16'd0, 24'd0, 1'b1, 17'd100000, 1'b1, PH_WAIT, 4'd0),
      dir_row(1'b0, 1'b1, 32'd2150, 16'd0, 24'd0, 1'b1, 17'd100000, 1'b0, PH_ANALYZE, 4'd0),
      // target of 300 Hz sits at equal weighted distance from 500 and 200
      dir_row(1'b0, 1'b1, 32'd2160, 16'd150, 24'd94, 1'b0, '0, 1'b0, PH_IDLE, 4'd0),
      dir_row(1'b1, 1'b0, 32'd2170, 16'd0, 24'd0, 1'b0, '0, 1'b0, PH_IDLE, 4'd0),
      dir_row(1'b0, 1'b1, 32'hFFFFFFFF, 16'hFFFF, 24'd0, 1'b0, '0, 1'b0, PH_IDLE, 4'd0)
    };
    repeat (7) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    for (i = 0; i < DIR_ROWS; i++)
      issue_pass(directed_rows[i].pass, directed_rows[i].typed, directed_rows[i].want);
    for (ph = 0; ph < SETTING_PHASES; ph++) begin
      case (ph)
        0: apply_settings(16'd150, 16'd150, 16'd6000, 1'b0);
        1: apply_settings(16'd0, 16'd0, 16'hFFFF, 1'b0);
        2: apply_settings(16'hFFFF, 16'hFFFF, 16'd0, 1'b0);
        3: apply_settings(16'($urandom_range(0, 3000)), 16'($urandom_range(0, 500)),
                          16'($urandom_range(0, 8000)), 1'b1);
        4: apply_settings(16'd150, 16'd0, 16'd0, 1'b0);
        default: apply_settings(16'($urandom), 16'($urandom_range(0, 400)),
                                16'($urandom_range(200, 2000)), 1'b0);
      endcase
      case (ph / 2)
        0: begin
          send_gap_pct = 35;
          recv_gap_pct = 81;
        end
        1: begin
          send_gap_pct = 81;
          recv_gap_pct = 35;
        end
        default: begin
          send_gap_pct = 0;
          recv_gap_pct = 0;
        end
      endcase
      // long output hold-off while passes keep coming
      if (ph == 4) hold_gen++;
      sess_left = 0;
      for (i = 0; i < PHASE_ITEMS; i++) begin
        make_pass(p);
        issue_pass(p, 1'b0, '0);
      end
    end
    s_tvalid <= 1'b0;
    while (timebase_queue.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("checked %0d result beats over %0d cycles and %0d register settings",
             results_seen, cycle_count, SETTING_PHASES);
    $display("scans started %0d, gears locked %0d, scans ending at the fallback rate %0d",
             restarts, locks_made, scans_failed);
    if (fail_count == 0)
      $display("scope_autoset_timebase verification clean");
    else
      $display("scope_autoset_timebase verification failed");
    $finish;
  end

endmodule
